[src/rau_pkg.sv]
`default_nettype none
package rau_pkg;
  localparam int unsigned OperandBits = 16;
  localparam int unsigned ResNumBits  = 32;
  localparam int unsigned ResDenBits  = 30;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } op_e;
endpackage
`default_nettype wire

[src/rau_if.sv]
`default_nettype none
interface rau_in_if #(parameter int unsigned OPERAND_BITS = rau_pkg::OperandBits);
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic signed [OPERAND_BITS-1:0] a_num;
  logic [OPERAND_BITS-2:0]   a_den;
  logic signed [OPERAND_BITS-1:0] b_num;
  logic [OPERAND_BITS-2:0]   b_den;
  modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [rau_pkg::ResNumBits-1:0]    res_num;
  logic [rau_pkg::ResDenBits-1:0]           res_den;
  logic                                     div_zero;
  modport source (output valid, res_num, res_den, div_zero, input ready);
  modport sink   (input valid, res_num, res_den, div_zero, output ready);
endinterface
`default_nettype wire

[src/rau_front.sv]
`default_nettype none
// Form raw numerator/denominator (one product per cycle) and push to queue.
module rau_front #(
  parameter int unsigned OPERAND_BITS = rau_pkg::OperandBits,
  localparam int unsigned PW = 2*OPERAND_BITS + 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  rau_in_if.sink                    in_i,
  output logic                      push_o,
  output logic signed [PW:0]        num_o,
  output logic signed [PW:0]        den_o,
  input  wire logic                 full_i
);
  typedef enum logic [2:0] {Idle, P0, P1, P2, Push} st_e;
  st_e st_q;
  logic [1:0] op_q;
  logic signed [OPERAND_BITS-1:0] an_q, bn_q;
  logic signed [OPERAND_BITS:0] ad_q, bd_q;
  logic signed [PW:0] t_q, num_q, den_q;
  logic signed [OPERAND_BITS:0] ma, mb;
  logic signed [2*OPERAND_BITS+1:0] prod;

  assign in_i.ready = (st_q == Idle);
  assign push_o = (st_q == Push) && !full_i;
  assign num_o = num_q;
  assign den_o = den_q;

  always_comb begin
    ma = {an_q[OPERAND_BITS-1], an_q};
    mb = bd_q;
    case (st_q)
      P0: begin ma = {an_q[OPERAND_BITS-1], an_q}; mb = (op_q == rau_pkg::OpMul) ?
            {bn_q[OPERAND_BITS-1], bn_q} : bd_q; end
      P1: begin ma = {bn_q[OPERAND_BITS-1], bn_q}; mb = ad_q; end
      P2: begin ma = ad_q; mb = (op_q == rau_pkg::OpDiv) ?
            {bn_q[OPERAND_BITS-1], bn_q} : bd_q; end
      default: ;
    endcase
    prod = ma * mb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= Idle;
    end else begin
      case (st_q)
        Idle: if (in_i.valid) st_q <= P0;
        P0: st_q <= P1;
        P1: st_q <= P2;
        P2: st_q <= Push;
        Push: if (!full_i) st_q <= Idle;
        default: st_q <= Idle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      Idle: begin
        op_q <= in_i.opcode;
        an_q <= in_i.a_num;
        bn_q <= in_i.b_num;
        ad_q <= {2'b00, in_i.a_den};
        bd_q <= {2'b00, in_i.b_den};
      end
      P0: t_q <= prod[PW:0];
      P1: begin
        case (op_q)
          rau_pkg::OpAdd: num_q <= t_q + prod[PW:0];
          rau_pkg::OpSub: num_q <= t_q - prod[PW:0];
          default:        num_q <= t_q;
        endcase
      end
      P2: den_q <= prod[PW:0];
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[src/rau_queue.sv]
`default_nettype none
// Two-entry queue between front and back.
module rau_queue #(
  parameter int unsigned W = 8,
  parameter int unsigned DEPTH = rau_pkg::QueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [W-1:0]  data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output logic [W-1:0]       data_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [W-1:0] mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0] cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end
endmodule
`default_nettype wire

[src/rau_back.sv]
`default_nettype none
// Normalise sign, binary GCD, then two restoring divisions by the GCD.
module rau_back #(
  parameter int unsigned OPERAND_BITS = rau_pkg::OperandBits,
  localparam int unsigned PW = 2*OPERAND_BITS + 1
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           empty_i,
  input  wire logic [2*PW+1:0] data_i,
  output logic                pop_o,
  rau_out_if.source           out_o
);
  localparam int unsigned MW = PW;
  localparam int unsigned SW = $clog2(MW+1);
  typedef enum logic [2:0] {Idle, Gcd, Shl, DivN, DivD, Out} st_e;
  st_e st_q;
  logic signed [PW:0] rn, rd;
  logic [MW-1:0] x_q, y_q, nm_q, dm_q, g_q, rem_q, quo_q, qn_q;
  logic [SW-1:0] k_q, cnt_q;
  logic neg_q;
  logic [MW:0] trial;
  logic [MW-1:0] remsh;

  assign rn = data_i[2*PW+1:PW+1];
  assign rd = data_i[PW:0];
  assign pop_o = (st_q == Idle) && !empty_i;
  assign out_o.valid = (st_q == Out);
  assign remsh = {rem_q[MW-2:0], quo_q[MW-1]};
  assign trial = {1'b0, remsh} - {1'b0, g_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= Idle;
    end else begin
      case (st_q)
        Idle: if (!empty_i) begin
          if (rd == '0 || rn == '0) st_q <= Out;
          else st_q <= Gcd;
        end
        Gcd: if (x_q == y_q) st_q <= Shl;
        Shl: st_q <= DivN;
        DivN: if (cnt_q == SW'(MW-1)) st_q <= DivD;
        DivD: if (cnt_q == SW'(MW-1)) st_q <= Out;
        Out: if (out_o.ready) st_q <= Idle;
        default: st_q <= Idle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      Idle: begin
        neg_q <= rn[PW] ^ rd[PW];
        nm_q  <= rn[PW] ? MW'(-rn) : MW'(rn);
        dm_q  <= rd[PW] ? MW'(-rd) : MW'(rd);
        x_q   <= rn[PW] ? MW'(-rn) : MW'(rn);
        y_q   <= rd[PW] ? MW'(-rd) : MW'(rd);
        k_q   <= '0;
        out_o.res_num <= '0;
        out_o.res_den <= rau_pkg::ResDenBits'(1);
        out_o.div_zero <= (rd == '0);
      end
      Gcd: begin
        // Binary GCD step: strip shared twos, then odd/even reduction.
        if (x_q != y_q) begin
          if (!x_q[0] && !y_q[0]) begin
            x_q <= x_q >> 1; y_q <= y_q >> 1; k_q <= k_q + 1'b1;
          end else if (!x_q[0]) x_q <= x_q >> 1;
          else if (!y_q[0]) y_q <= y_q >> 1;
          else if (x_q > y_q) x_q <= (x_q - y_q) >> 1;
          else y_q <= (y_q - x_q) >> 1;
        end
      end
      Shl: begin
        g_q <= x_q << k_q;
        rem_q <= '0; quo_q <= nm_q; cnt_q <= '0;
      end
      DivN, DivD: begin
        if (cnt_q == SW'(MW-1)) begin
          cnt_q <= '0; rem_q <= '0;
          if (st_q == DivN) begin
            qn_q <= trial[MW] ? {quo_q[MW-2:0], 1'b0} : {quo_q[MW-2:0], 1'b1};
            quo_q <= dm_q;
          end else begin
            out_o.res_num <= neg_q ? -rau_pkg::ResNumBits'(qn_q)
                                   : rau_pkg::ResNumBits'(qn_q);
            out_o.res_den <= trial[MW] ? rau_pkg::ResDenBits'({quo_q[MW-2:0], 1'b0})
                                       : rau_pkg::ResDenBits'({quo_q[MW-2:0], 1'b1});
            out_o.div_zero <= 1'b0;
          end
        end else begin
          cnt_q <= cnt_q + 1'b1;
          if (!trial[MW]) begin
            rem_q <= trial[MW-1:0]; quo_q <= {quo_q[MW-2:0], 1'b1};
          end else begin
            rem_q <= remsh; quo_q <= {quo_q[MW-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_out_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.res_den != '0) else $error("zero denominator");
  a_dz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.div_zero |-> out_o.res_num == '0) else $error("div zero num");
  a_gcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == Gcd |-> x_q != '0 && y_q != '0) else $error("gcd operand zero");
`endif
endmodule
`default_nettype wire

[src/rational_arithmetic_unit.sv]
`default_nettype none
// Rational arithmetic unit: add, subtract, multiply, divide of two rationals.
// Flow: the front end forms the raw fraction, then the back end runs binary GCD
// steps and restoring division steps.
// Throughput: one item per back-end pass; the GCD and divider loop sets it.
// Reset: rst_ni asynchronous active low clears control state and the queue.
module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_BITS = rau_pkg::OperandBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rau_in_if.sink    in_i,
  rau_out_if.source out_o
);
  localparam int unsigned PW = 2*OPERAND_BITS + 1;
  logic push, full, pop, empty;
  logic signed [PW:0] num, den;
  logic [2*PW+1:0] qdata;

  // Front: accept item, form raw fraction.
  rau_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
    .clk_i, .rst_ni, .in_i, .push_o(push), .num_o(num), .den_o(den), .full_i(full));

  // Hold raw fractions so front and back stall independently.
  rau_queue #(.W(2*PW+2)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i({num, den}), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(qdata));

  // Back: reduce and deliver.
  rau_back #(.OPERAND_BITS(OPERAND_BITS)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .data_i(qdata), .pop_o(pop), .out_o);
endmodule
`default_nettype wire
